>>> hw/rtl/skr_pkg.sv
// Shared types and constants for the session-key response parser.
`default_nettype none
package skr_pkg;

  localparam int unsigned MaxKeysDefault      = 16;
  localparam int unsigned MaxSpecBytesDefault = 255;

  localparam int unsigned NonceBytes  = 8;
  localparam int unsigned CountBytes  = 4;
  localparam int unsigned IdBytes     = 8;
  localparam int unsigned ExpiryBytes = 6;
  localparam int unsigned RelBytes    = 6;
  localparam int unsigned VarintMaxGroups = 5;

  typedef enum logic [3:0] {
    KindNonce    = 4'd0,
    KindSpecByte = 4'd1,
    KindKeyCount = 4'd2,
    KindKeyId    = 4'd3,
    KindRelValid = 4'd4,
    KindCipher   = 4'd5,
    KindMac      = 4'd6,
    KindDone     = 4'd7,
    KindError    = 4'd8
  } field_kind_e;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrVarint     = 3'd1,
    ErrSpecLong   = 3'd2,
    ErrTooMany    = 3'd3,
    ErrEarlyEnd   = 3'd4
  } err_code_e;

  typedef struct packed {
    field_kind_e field_kind;
    logic [63:0] field_value;
    logic [3:0]  key_number;
    logic [7:0]  byte_number;
    err_code_e   error_code;
    logic        run_last;
  } skr_result_t;

  // Results produced by one accepted beat, first slot used first.
  typedef struct packed {
    logic [1:0]  count;
    skr_result_t res0;
    skr_result_t res1;
  } skr_push_t;

endpackage
`default_nettype wire

>>> hw/rtl/skr_in_if.sv
// Input byte channel.
`default_nettype none
interface skr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/skr_out_if.sv
// Result channel.
`default_nettype none
interface skr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [63:0] field_value;
  logic [3:0]  key_number;
  logic [7:0]  byte_number;
  logic [2:0]  error_code;
  logic        run_last;

  modport source (output valid, output field_kind, output field_value, output key_number,
                  output byte_number, output error_code, output run_last, input ready);
  modport sink (input valid, input field_kind, input field_value, input key_number,
                input byte_number, input error_code, input run_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/skr_core.sv
// Parse state and per-byte decode; yields up to two results per beat.
`default_nettype none
module skr_core
  import skr_pkg::*;
#(
  parameter int unsigned MAX_KEYS       = MaxKeysDefault,
  parameter int unsigned MAX_SPEC_BYTES = MaxSpecBytesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      beat_i,
  input  wire logic [7:0] byte_i,
  input  wire logic      last_i,
  output skr_push_t      push_o
);

  localparam int unsigned KeyCntW = $clog2(MAX_KEYS + 1);

  typedef enum logic [3:0] {
    PhNonce   = 4'd0,
    PhSpecLen = 4'd1,
    PhSpec    = 4'd2,
    PhCount   = 4'd3,
    PhId      = 4'd4,
    PhExpiry  = 4'd5,
    PhRel     = 4'd6,
    PhCLen    = 4'd7,
    PhCipher  = 4'd8,
    PhMLen    = 4'd9,
    PhMac     = 4'd10
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         bcnt_q, bcnt_d;
  logic [63:0]        acc_q, acc_d;
  logic [2:0]         grp_q, grp_d;
  logic [7:0]         srem_q, srem_d;
  logic [KeyCntW-1:0] krem_q, krem_d;
  logic [3:0]         kidx_q, kidx_d;
  logic               halt_q, halt_d;

  logic [63:0]        acc_shift;
  logic [7:0]         bcnt_inc;
  logic [7:0]         srem_dec;
  logic [KeyCntW-1:0] krem_dec;
  logic [34:0]        vlen;
  logic [31:0]        kcnt;
  logic               has_data, has_term, done, finished;
  err_code_e          err;
  skr_result_t        data_r, term_r;

  assign acc_shift = {acc_q[55:0], byte_i};
  assign bcnt_inc  = bcnt_q + 8'd1;
  assign srem_dec  = (srem_q != 8'd0) ? srem_q - 8'd1 : srem_q;
  assign krem_dec  = (krem_q != '0) ? krem_q - KeyCntW'(1) : krem_q;
  assign vlen      = acc_q[34:0] | (35'(byte_i[6:0]) << (7 * grp_q));
  assign kcnt      = acc_shift[31:0];

  always_comb begin
    phase_d  = phase_q;
    bcnt_d   = bcnt_q;
    acc_d    = acc_q;
    grp_d    = grp_q;
    srem_d   = srem_q;
    krem_d   = krem_q;
    kidx_d   = kidx_q;
    halt_d   = halt_q;
    has_data = 1'b0;
    has_term = 1'b0;
    done     = 1'b0;
    err      = ErrNone;
    finished = 1'b0;
    data_r   = '{field_kind: KindNonce, field_value: '0, key_number: '0,
                 byte_number: '0, error_code: ErrNone, run_last: 1'b0};
    term_r   = '{field_kind: KindDone, field_value: '0, key_number: '0,
                 byte_number: '0, error_code: ErrNone, run_last: 1'b1};

    if (halt_q) begin
      if (last_i) begin
        phase_d = PhNonce;
        bcnt_d  = '0;
        acc_d   = '0;
        grp_d   = '0;
        srem_d  = '0;
        krem_d  = '0;
        kidx_d  = '0;
        halt_d  = 1'b0;
      end
    end else begin
      case (phase_q)
        PhNonce: begin
          acc_d  = acc_shift;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 8'(NonceBytes)) begin
            bcnt_d   = '0;
            has_data = 1'b1;
            data_r.field_kind  = KindNonce;
            data_r.field_value = acc_shift;
            acc_d   = '0;
            grp_d   = '0;
            phase_d = PhSpecLen;
          end
        end
        PhSpecLen: begin
          acc_d = {29'd0, vlen};
          grp_d = grp_q + 3'd1;
          if (!byte_i[7]) begin
            acc_d  = '0;
            grp_d  = '0;
            bcnt_d = '0;
            if (vlen > 35'(MAX_SPEC_BYTES)) begin
              err = ErrSpecLong;
            end else if (vlen == '0) begin
              phase_d = PhCount;
            end else begin
              srem_d  = vlen[7:0];
              phase_d = PhSpec;
            end
          end else if (grp_d >= 3'(VarintMaxGroups)) begin
            err = ErrVarint;
          end
        end
        PhSpec: begin
          has_data = 1'b1;
          data_r.field_kind  = KindSpecByte;
          data_r.field_value = 64'(byte_i);
          data_r.byte_number = bcnt_q;
          bcnt_d = bcnt_inc;
          srem_d = srem_dec;
          if (srem_dec == 8'd0) begin
            bcnt_d  = '0;
            acc_d   = '0;
            phase_d = PhCount;
          end
        end
        PhCount: begin
          acc_d  = acc_shift;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 8'(CountBytes)) begin
            bcnt_d   = '0;
            has_data = 1'b1;
            data_r.field_kind  = KindKeyCount;
            data_r.field_value = 64'(kcnt);
            acc_d = '0;
            if (kcnt > 32'(MAX_KEYS)) begin
              err = ErrTooMany;
            end else if (kcnt == '0) begin
              done = 1'b1;
            end else begin
              krem_d  = kcnt[KeyCntW-1:0];
              kidx_d  = '0;
              phase_d = PhId;
            end
          end
        end
        PhId: begin
          acc_d  = acc_shift;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 8'(IdBytes)) begin
            bcnt_d   = '0;
            has_data = 1'b1;
            data_r.field_kind  = KindKeyId;
            data_r.field_value = acc_shift;
            data_r.key_number  = kidx_q;
            acc_d   = '0;
            phase_d = PhExpiry;
          end
        end
        PhExpiry: begin
          acc_d  = acc_shift;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 8'(ExpiryBytes)) begin
            bcnt_d  = '0;
            acc_d   = '0;
            phase_d = PhRel;
          end
        end
        PhRel: begin
          acc_d  = acc_shift;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 8'(RelBytes)) begin
            bcnt_d   = '0;
            has_data = 1'b1;
            data_r.field_kind  = KindRelValid;
            data_r.field_value = {16'd0, acc_shift[47:0]};
            data_r.key_number  = kidx_q;
            acc_d   = '0;
            phase_d = PhCLen;
          end
        end
        PhCLen: begin
          bcnt_d = '0;
          if (byte_i == 8'd0) begin
            phase_d = PhMLen;
          end else begin
            srem_d  = byte_i;
            phase_d = PhCipher;
          end
        end
        PhCipher: begin
          has_data = 1'b1;
          data_r.field_kind  = KindCipher;
          data_r.field_value = 64'(byte_i);
          data_r.key_number  = kidx_q;
          data_r.byte_number = bcnt_q;
          bcnt_d = bcnt_inc;
          srem_d = srem_dec;
          if (srem_dec == 8'd0) begin
            bcnt_d  = '0;
            phase_d = PhMLen;
          end
        end
        PhMLen: begin
          bcnt_d = '0;
          if (byte_i == 8'd0) begin
            krem_d  = krem_dec;
            kidx_d  = kidx_q + 4'd1;
            phase_d = PhId;
            acc_d   = '0;
            done    = (krem_dec == '0);
          end else begin
            srem_d  = byte_i;
            phase_d = PhMac;
          end
        end
        PhMac: begin
          has_data = 1'b1;
          data_r.field_kind  = KindMac;
          data_r.field_value = 64'(byte_i);
          data_r.key_number  = kidx_q;
          data_r.byte_number = bcnt_q;
          bcnt_d = bcnt_inc;
          srem_d = srem_dec;
          if (srem_dec == 8'd0) begin
            krem_d  = krem_dec;
            kidx_d  = kidx_q + 4'd1;
            phase_d = PhId;
            bcnt_d  = '0;
            acc_d   = '0;
            done    = (krem_dec == '0);
          end
        end
        default: begin
          phase_d = PhNonce;
          bcnt_d  = '0;
          acc_d   = '0;
          grp_d   = '0;
          srem_d  = '0;
          krem_d  = '0;
          kidx_d  = '0;
        end
      endcase

      if (err != ErrNone) begin
        has_term = 1'b1;
        term_r.field_kind = KindError;
        term_r.error_code = err;
      end else if (done) begin
        has_term = 1'b1;
      end else if (last_i) begin
        has_term = 1'b1;
        term_r.field_kind = KindError;
        term_r.error_code = ErrEarlyEnd;
      end
      finished = has_term;

      if (finished) begin
        if (last_i) begin
          phase_d = PhNonce;
          bcnt_d  = '0;
          acc_d   = '0;
          grp_d   = '0;
          srem_d  = '0;
          krem_d  = '0;
          kidx_d  = '0;
          halt_d  = 1'b0;
        end else begin
          halt_d = 1'b1;
        end
      end
    end

    data_r.run_last = !has_term;
    push_o.count = beat_i ? (2'(has_data) + 2'(has_term)) : 2'd0;
    push_o.res0  = has_data ? data_r : term_r;
    push_o.res1  = term_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNonce;
      bcnt_q  <= '0;
      acc_q   <= '0;
      grp_q   <= '0;
      srem_q  <= '0;
      krem_q  <= '0;
      kidx_q  <= '0;
      halt_q  <= 1'b0;
    end else if (beat_i) begin
      phase_q <= phase_d;
      bcnt_q  <= bcnt_d;
      acc_q   <= acc_d;
      grp_q   <= grp_d;
      srem_q  <= srem_d;
      krem_q  <= krem_d;
      kidx_q  <= kidx_d;
      halt_q  <= halt_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/skr_outq.sv
// Four-entry result queue; takes up to two results a cycle, gives one while ready_i is high.
`default_nettype none
module skr_outq
  import skr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire skr_push_t push_i,
  output logic           space_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output skr_result_t    head_o
);

  skr_result_t mem_q [4];
  logic [1:0]  wptr_q, rptr_q;
  logic [2:0]  cnt_q, cnt_d;
  logic        pop;

  assign valid_o = (cnt_q != 3'd0);
  assign space_o = (cnt_q <= 3'd2);
  assign head_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign cnt_d   = cnt_q + 3'(push_i.count) - 3'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_i.count;
      rptr_q <= rptr_q + 2'(pop);
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/session_key_response_parser.sv
// Top level of the session-key response parser.
//
//   channel  dir  payload                                   beat
//   in_i     in   in_byte, in_last                          one message byte
//   out_o    out  field_kind/value, key/byte no, err, last  one decoded result
//
// One byte accepted per cycle while in_i.ready is high; its results land in a
// four-entry queue the next cycle and leave one per cycle while out_o.ready is
// high, so a byte's two results leave one after the other. in_i.ready is low while the queue holds three or more.
// Reset clears parse state and the queue; out_o stalls back up the queue and, through in_i.ready, the input.
`default_nettype none
module session_key_response_parser
  import skr_pkg::*;
#(
  parameter int unsigned MAX_KEYS       = MaxKeysDefault,
  parameter int unsigned MAX_SPEC_BYTES = MaxSpecBytesDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skr_in_if.sink    in_i,
  skr_out_if.source out_o
);

  skr_push_t   push;
  skr_result_t head;
  logic        space;
  logic        beat;

  assign in_i.ready = space;
  assign beat       = in_i.valid && space;

  skr_core #(
    .MAX_KEYS       (MAX_KEYS),
    .MAX_SPEC_BYTES (MAX_SPEC_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (in_i.in_byte),
    .last_i (in_i.in_last),
    .push_o (push)
  );

  skr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.field_kind  = head.field_kind;
  assign out_o.field_value = head.field_value;
  assign out_o.key_number  = head.key_number;
  assign out_o.byte_number = head.byte_number;
  assign out_o.error_code  = head.error_code;
  assign out_o.run_last    = head.run_last;

endmodule
`default_nettype wire

>>> sim/session_key_response_parser_tb.sv
// Testbench for the session-key response parser: directed and random messages against a model.
`timescale 1ns / 1ps
module session_key_response_parser_tb;
  import skr_pkg::*;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 5;
  localparam int unsigned IdlePct       = 83;
  localparam int unsigned BothIdlePct   = 8;
  localparam int unsigned PhaseBytes    = 40;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned MaxReports    = 100;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef enum logic [3:0] {
    StNonce, StSpecLen, StSpec, StCount, StKeyId, StExpiry, StRelValid,
    StCipherLen, StCipher, StMacLen, StMac
  } msg_state_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  skr_in_if  in_if ();
  skr_out_if out_if ();

  session_key_response_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  idle_mode_e  idle_mode = IdleNone;
  int unsigned error_count = 0;
  int unsigned live_bytes = 0;
  int unsigned quiet_cycles = 0;

  skr_result_t expected_results[$];
  logic [7:0]  msg_bytes[$];

  // parser model state
  msg_state_e  msg_state;
  logic [7:0]  field_bytes;
  logic [63:0] shift_acc;
  logic [2:0]  varint_groups;
  logic [7:0]  string_left;
  logic [4:0]  keys_left;
  logic [3:0]  cur_key;
  logic        parser_halted;

  function automatic void clear_parser();
    msg_state     = StNonce;
    field_bytes   = '0;
    shift_acc     = '0;
    varint_groups = '0;
    string_left   = '0;
    keys_left     = '0;
    cur_key       = '0;
    parser_halted = 1'b0;
  endfunction

  function automatic bit shift_byte(input logic [7:0] b, input int unsigned n);
    shift_acc = {shift_acc[55:0], b};
    field_bytes++;
    if (field_bytes >= n) begin
      field_bytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit close_key();
    if (keys_left > 0) keys_left--;
    cur_key++;
    msg_state   = StKeyId;
    field_bytes = '0;
    shift_acc   = '0;
    return keys_left == 0;
  endfunction

  function automatic void add_result(input field_kind_e kind, input logic [63:0] value,
                                     input logic [3:0] key, input logic [7:0] pos,
                                     input err_code_e err);
    skr_result_t r;
    r.field_kind  = kind;
    r.field_value = value;
    r.key_number  = key;
    r.byte_number = pos;
    r.error_code  = err;
    r.run_last    = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic string describe(input skr_result_t r);
    return $sformatf("kind=%0d value=%h key=%0d byte=%0d err=%0d last=%0b", r.field_kind,
                     r.field_value, r.key_number, r.byte_number, r.error_code, r.run_last);
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic is_last);
    int unsigned first;
    logic        finished;
    logic        done;
    err_code_e   err;
    logic [63:0] len;
    skr_result_t tail;
    first    = expected_results.size();
    finished = 1'b0;
    done     = 1'b0;
    err      = ErrNone;
    if (parser_halted) begin
      if (is_last) clear_parser();
      return;
    end
    case (msg_state)
      StNonce: begin
        if (shift_byte(b, NonceBytes)) begin
          add_result(KindNonce, shift_acc, '0, '0, ErrNone);
          shift_acc     = '0;
          varint_groups = '0;
          msg_state     = StSpecLen;
        end
      end
      StSpecLen: begin
        shift_acc |= {57'd0, b[6:0]} << (7 * varint_groups);
        varint_groups++;
        if (!b[7]) begin
          len           = shift_acc;
          shift_acc     = '0;
          varint_groups = '0;
          field_bytes   = '0;
          if (len > MaxSpecBytesDefault) err = ErrSpecLong;
          else if (len == 0) msg_state = StCount;
          else begin
            string_left = len[7:0];
            msg_state   = StSpec;
          end
        end else if (varint_groups >= VarintMaxGroups) begin
          err = ErrVarint;
        end
      end
      StSpec: begin
        add_result(KindSpecByte, {56'd0, b}, '0, field_bytes, ErrNone);
        field_bytes++;
        if (string_left > 0) string_left--;
        if (string_left == 0) begin
          field_bytes = '0;
          shift_acc   = '0;
          msg_state   = StCount;
        end
      end
      StCount: begin
        if (shift_byte(b, CountBytes)) begin
          len = {32'd0, shift_acc[31:0]};
          add_result(KindKeyCount, len, '0, '0, ErrNone);
          shift_acc = '0;
          if (len > MaxKeysDefault) err = ErrTooMany;
          else if (len == 0) done = 1'b1;
          else begin
            keys_left = len[4:0];
            cur_key   = '0;
            msg_state = StKeyId;
          end
        end
      end
      StKeyId: begin
        if (shift_byte(b, IdBytes)) begin
          add_result(KindKeyId, shift_acc, cur_key, '0, ErrNone);
          shift_acc = '0;
          msg_state = StExpiry;
        end
      end
      StExpiry: begin
        if (shift_byte(b, ExpiryBytes)) begin
          shift_acc = '0;
          msg_state = StRelValid;
        end
      end
      StRelValid: begin
        if (shift_byte(b, RelBytes)) begin
          add_result(KindRelValid, {16'd0, shift_acc[47:0]}, cur_key, '0, ErrNone);
          shift_acc = '0;
          msg_state = StCipherLen;
        end
      end
      StCipherLen: begin
        field_bytes = '0;
        if (b == 0) msg_state = StMacLen;
        else begin
          string_left = b;
          msg_state   = StCipher;
        end
      end
      StCipher: begin
        add_result(KindCipher, {56'd0, b}, cur_key, field_bytes, ErrNone);
        field_bytes++;
        if (string_left > 0) string_left--;
        if (string_left == 0) begin
          field_bytes = '0;
          msg_state   = StMacLen;
        end
      end
      StMacLen: begin
        field_bytes = '0;
        if (b == 0) done = close_key();
        else begin
          string_left = b;
          msg_state   = StMac;
        end
      end
      StMac: begin
        add_result(KindMac, {56'd0, b}, cur_key, field_bytes, ErrNone);
        field_bytes++;
        if (string_left > 0) string_left--;
        if (string_left == 0) done = close_key();
      end
      default: clear_parser();
    endcase

    if (err != ErrNone) begin
      add_result(KindError, '0, '0, '0, err);
      finished = 1'b1;
    end else if (done) begin
      add_result(KindDone, '0, '0, '0, ErrNone);
      finished = 1'b1;
    end else if (is_last) begin
      add_result(KindError, '0, '0, '0, ErrEarlyEnd);
      finished = 1'b1;
    end
    if (finished) begin
      if (is_last) clear_parser();
      else parser_halted = 1'b1;
    end
    if (expected_results.size() > first) begin
      tail          = expected_results.pop_back();
      tail.run_last = 1'b1;
      expected_results.push_back(tail);
    end
  endfunction

  function automatic bit idle_draw(input bit receiver_side);
    case (idle_mode)
      IdleSender:   return !receiver_side && $urandom_range(99) < IdlePct;
      IdleReceiver: return receiver_side && $urandom_range(99) < IdlePct;
      IdleBoth:     return $urandom_range(99) < BothIdlePct;
      default:      return 1'b0;
    endcase
  endfunction

  // message building
  function automatic void put_be(input logic [63:0] v, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) msg_bytes.push_back(8'($urandom));
  endfunction

  // pad adds redundant zero groups, up to the group limit
  function automatic void put_varint(input logic [63:0] len, input int unsigned pad);
    int unsigned groups;
    groups = 1;
    while (groups < VarintMaxGroups && (len >> (7 * groups)) != 0) groups++;
    groups = (groups + pad > VarintMaxGroups) ? VarintMaxGroups : groups + pad;
    for (int unsigned i = 0; i < groups; i++) msg_bytes.push_back({i < groups - 1, len[7*i +: 7]});
  endfunction

  function automatic void put_key(input int unsigned cipher_len, input int unsigned mac_len);
    put_random(IdBytes + ExpiryBytes + RelBytes);
    msg_bytes.push_back(8'(cipher_len));
    put_random(cipher_len);
    msg_bytes.push_back(8'(mac_len));
    put_random(mac_len);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (idle_draw(1'b0)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!parser_halted) live_bytes++;
    predict_byte(b, is_last);
    @(negedge clk_i);
  endtask

  // sends the built message with in_last on its final byte
  task automatic send_msg();
    for (int unsigned i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic test_short_messages();
    idle_mode = IdleNone;
    // all-ones nonce, empty spec, no keys: done lands on the last byte
    put_be('1, NonceBytes);
    put_varint(0, 0);
    put_be(0, CountBytes);
    send_msg();
    // unterminated length, then a byte that only re-arms
    put_be(0, NonceBytes);
    put_be(64'hFF_FFFF_FFFF, VarintMaxGroups);
    msg_bytes.push_back(8'h7F);
    send_msg();
    // message cut short inside the nonce
    put_be(64'h80_7F, 2);
    send_msg();
  endtask

  task automatic test_length_limits();
    idle_mode = IdleReceiver;
    put_random(NonceBytes);
    put_varint(MaxSpecBytesDefault, 0);
    put_random(MaxSpecBytesDefault);
    put_be(MaxKeysDefault, CountBytes);
    for (int unsigned i = 0; i < MaxKeysDefault; i++) put_key(i == 0, i == MaxKeysDefault - 1);
    put_random(2);
    send_msg();
    put_random(NonceBytes);
    put_varint(0, 0);
    put_be(MaxKeysDefault + 1, CountBytes);
    put_random(2);
    send_msg();
    put_random(NonceBytes);
    put_varint(MaxSpecBytesDefault + 1, 0);
    put_random(2);
    send_msg();
  endtask

  task automatic send_random_message();
    int unsigned pick;
    int unsigned spec_len;
    int unsigned n_keys;
    int unsigned keep;
    logic [63:0] big;
    pick = $urandom_range(99);
    put_random(NonceBytes);
    if (pick < 6) begin
      for (int unsigned i = 0; i < VarintMaxGroups; i++) msg_bytes.push_back(8'h80 | 8'($urandom));
      put_random($urandom_range(3));
    end else if (pick < 12) begin
      big = $urandom_range(1) ? 64'(MaxSpecBytesDefault + 1 + $urandom_range(7))
                              : {$urandom, $urandom} & 64'h7_FFFF_FFFF;
      if (big <= MaxSpecBytesDefault) big += 256;
      put_varint(big, $urandom_range(2));
      put_random($urandom_range(3));
    end else begin
      spec_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
      put_varint(spec_len, ($urandom_range(3) == 0) ? $urandom_range(4) : 0);
      put_random(spec_len);
      if ($urandom_range(11) == 0) begin
        big = $urandom_range(1) ? 64'(MaxKeysDefault + 1 + $urandom_range(3))
                                : {32'd0, $urandom | 32'h100};
        put_be(big, CountBytes);
        put_random($urandom_range(3));
      end else begin
        n_keys = $urandom_range(3);
        put_be(n_keys, CountBytes);
        for (int unsigned i = 0; i < n_keys; i++) put_key($urandom_range(5), $urandom_range(5));
        if ($urandom_range(4) == 0) put_random(1 + $urandom_range(2));
      end
    end
    if ($urandom_range(7) == 0) begin
      keep = 1 + $urandom_range(msg_bytes.size() - 1);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
    send_msg();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int k = 0; k < 4; k++) begin
      idle_mode = idle_mode_e'(k);
      stop_at   = live_bytes + PhaseBytes;
      while (live_bytes < stop_at) send_random_message();
    end
  endtask

  always @(negedge clk_i) out_if.ready <= !idle_draw(1'b1);

  always @(posedge clk_i) begin : check_results
    skr_result_t seen;
    skr_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen = {out_if.field_kind, out_if.field_value, out_if.key_number, out_if.byte_number,
              out_if.error_code, out_if.run_last};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t: unexpected result kind=%0d value=%h", $time, seen.field_kind,
                   seen.field_value);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: mismatch expected %s, actual %s", $time, describe(want),
                     describe(seen));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    clear_parser();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_messages();
    test_length_limits();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
